/* sv/fecp_pkg.sv */
`timescale 1ns / 1ps

package fecp_pkg;

  // Result kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Payload history: one bank being written plus two committed frames
  localparam int NUM_BANKS = 3;

  typedef logic [1:0] bank_idx_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] seq_low;
    logic       has_fec;
    logic [7:0] byte_index;
    logic [7:0] payload_byte;
    logic [7:0] parity_byte;
    logic       parity_valid;
    logic       frame_done;
    logic       frame_abort;
  } out_t;

endpackage

/* sv/fecp_ram.sv */
`timescale 1ns / 1ps

module fecp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port: write, or registered read that holds when idle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/xor_parity_fec_packetizer_core.sv */
// XOR parity FEC packetizer. Takes a datagram one byte per request: SEQ_BYTES
// bytes of big-endian sequence number, then PAYLOAD_BYTES of payload. The last
// sequence byte yields a header result (low sequence byte, FEC flag set on even
// sequence); each payload byte yields a result carrying the byte and the XOR
// of the two previously committed payloads at that index, valid on FEC frames.
// A datagram that ends early yields one abort result and commits nothing; bytes
// beyond the frame are dropped until in_last. The block accepts one byte every
// cycle unless out_ready stalls the result path; a result passes first through
// the registered read of the single-port payload banks (three banks, one
// written while the other two are read in the same cycle) and then through the
// output register. History banks that were never committed read as zero
// through per-bank committed flags, so no clearing pass follows reset.
`timescale 1ns / 1ps

module xor_parity_fec_packetizer_core #(
  parameter int PAYLOAD_BYTES = 160,
  parameter int SEQ_BYTES     = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fecp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output fecp_pkg::out_t out_data
);

  localparam int FRAME_BYTES = SEQ_BYTES + PAYLOAD_BYTES;
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W       = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  localparam logic [POS_W-1:0] FRAME_POS    = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0] DONE_POS     = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] SEQ_POS      = POS_W'(SEQ_BYTES);
  localparam logic [POS_W-1:0] SEQ_LAST_POS = POS_W'(SEQ_BYTES - 1);

  // Control state
  logic [POS_W-1:0]                  pos_r, pos_nxt;
  fecp_pkg::bank_idx_t               rot_r, rot_nxt;
  logic [fecp_pkg::NUM_BANKS-1:0]    comm_r, comm_nxt;
  logic [7:0]                        seq_r, seq_nxt;

  // Read stage and output register
  logic                              s1_v_r, s1_v_nxt;
  fecp_pkg::out_t                    s1_r, s1_nxt;
  logic [fecp_pkg::NUM_BANKS-1:0]    s1_mask_r, s1_mask_nxt;
  logic                              out_v_r, out_v_nxt;
  fecp_pkg::out_t                    out_r, out_nxt;

  logic                              in_fire;
  logic                              s1_adv;
  logic                              pay_fire;
  logic                              done;
  logic                              fec;
  logic [IDX_W-1:0]                  idx;
  logic [fecp_pkg::NUM_BANKS-1:0]    cur_oh;
  logic [fecp_pkg::NUM_BANKS-1:0]    bank_we;
  logic [7:0]                        bank_rd [fecp_pkg::NUM_BANKS];
  logic [7:0]                        parity;

  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign idx = IDX_W'(pos_r - SEQ_POS);
  assign fec = !seq_r[0];

  // Decode the write bank
  always_comb begin
    case (rot_r)
      2'd1:    cur_oh = 3'b010;
      2'd2:    cur_oh = 3'b100;
      default: cur_oh = 3'b001;
    endcase
  end

  // Classify the request and update frame state
  always_comb begin
    pos_nxt     = pos_r;
    rot_nxt     = rot_r;
    comm_nxt    = comm_r;
    seq_nxt     = seq_r;
    s1_v_nxt    = s1_v_r && !s1_adv;
    s1_nxt      = s1_r;
    s1_mask_nxt = s1_mask_r;
    pay_fire    = 1'b0;
    done        = (pos_r == DONE_POS);

    if (in_fire) begin
      s1_nxt      = '0;
      s1_mask_nxt = '0;
      if (pos_r >= FRAME_POS) begin
        // drop bytes past the frame
        if (in_data.in_last) begin
          pos_nxt = '0;
        end
      end else if (in_data.in_last && pos_r < DONE_POS) begin
        // short datagram
        pos_nxt            = '0;
        s1_v_nxt           = 1'b1;
        s1_nxt.kind        = fecp_pkg::KIND_HEADER;
        s1_nxt.frame_abort = 1'b1;
      end else if (pos_r < SEQ_POS) begin
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r == SEQ_LAST_POS) begin
          seq_nxt        = in_data.in_byte;
          s1_v_nxt       = 1'b1;
          s1_nxt.kind    = fecp_pkg::KIND_HEADER;
          s1_nxt.seq_low = in_data.in_byte;
          s1_nxt.has_fec = !in_data.in_byte[0];
        end
      end else begin
        pay_fire            = 1'b1;
        s1_v_nxt            = 1'b1;
        s1_nxt.kind         = fecp_pkg::KIND_PAYLOAD;
        s1_nxt.has_fec      = fec;
        s1_nxt.byte_index   = 8'(idx);
        s1_nxt.payload_byte = in_data.in_byte;
        s1_nxt.parity_valid = fec;
        s1_nxt.frame_done   = done;
        s1_mask_nxt         = comm_r & ~cur_oh;
        if (done) begin
          comm_nxt = comm_r | cur_oh;
          case (rot_r)
            2'd0:    rot_nxt = 2'd1;
            2'd1:    rot_nxt = 2'd2;
            default: rot_nxt = 2'd0;
          endcase
          pos_nxt = in_data.in_last ? '0 : FRAME_POS;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  // Payload banks: write the current one, read the two history banks
  assign bank_we = pay_fire ? cur_oh : '0;

  for (genvar g = 0; g < fecp_pkg::NUM_BANKS; g++) begin : g_bank
    fecp_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_BYTES)
    ) u_bank (
      .clk   (clk),
      .en    (pay_fire),
      .we    (bank_we[g]),
      .addr  (idx),
      .wdata (in_data.in_byte),
      .rdata (bank_rd[g])
    );
  end

  // Combine committed history; uncommitted banks read as zero
  always_comb begin
    parity = '0;
    for (int b = 0; b < fecp_pkg::NUM_BANKS; b++) begin
      if (s1_mask_r[b]) begin
        parity = parity ^ bank_rd[b];
      end
    end
  end

  // Advance the read stage into the output register
  always_comb begin
    out_v_nxt = out_v_r && !out_ready;
    out_nxt   = out_r;
    if (s1_v_r && s1_adv) begin
      out_v_nxt           = 1'b1;
      out_nxt             = s1_r;
      out_nxt.parity_byte = parity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      rot_r   <= '0;
      comm_r  <= '0;
      seq_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      rot_r   <= rot_nxt;
      comm_r  <= comm_nxt;
      seq_r   <= seq_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r      <= s1_nxt;
    s1_mask_r <= s1_mask_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Checks
  a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_abort |->
      out_data.kind == fecp_pkg::KIND_HEADER && !out_data.parity_valid &&
      out_data.parity_byte == 8'd0)
    else $error("abort result carries payload fields");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we) && (bank_we & s1_mask_nxt) == '0)
    else $error("bank written while read as history");

  a_rotate: assert property (@(posedge clk) disable iff (!rst_n)
    pay_fire && done |=> rot_r != $past(rot_r) && $countones(comm_r) >= 1)
    else $error("commit did not rotate banks");

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_r) && $stable(s1_mask_r))
    else $error("read stage lost while stalled");

endmodule

/* tb/xor_parity_fec_packetizer_core_test.sv */
`timescale 1ns / 1ps

module xor_parity_fec_packetizer_core_test;

  localparam int PAYLOAD_BYTES = 160;
  localparam int SEQ_BYTES     = 4;
  localparam int FRAME_BYTES   = SEQ_BYTES + PAYLOAD_BYTES;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 200000;

  // Directed datagrams as {byte, last}: short ones ending at each stage
  localparam logic [8:0] DIRECTED [21] = '{
    {8'h00, 1'b1},
    {8'h12, 1'b0}, {8'h34, 1'b0}, {8'h56, 1'b1},
    {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b1},
    {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b1},
    {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h80, 1'b0}, {8'hFE, 1'b0},
    {8'h00, 1'b0}, {8'hA5, 1'b0}, {8'h5A, 1'b0}, {8'hFF, 1'b1}
  };

  // Frame tracker and parity history; holds the results still owed by the block
  class fec_scoreboard;
    logic [7:0]      history [0:2][0:PAYLOAD_BYTES-1];
    int unsigned     write_bank;
    int unsigned     frame_pos;
    logic [7:0]      frame_seq_low;
    fecp_pkg::out_t  owed_results[$];
    int unsigned     mismatches;
    int unsigned     requests;
    int unsigned     checked;
    int unsigned     headers;
    int unsigned     payload_bytes;
    int unsigned     aborts;
    int unsigned     commits;

    function new();
      for (int b = 0; b < 3; b++)
        for (int i = 0; i < PAYLOAD_BYTES; i++)
          history[b][i] = 8'h00;
      write_bank    = 0;
      frame_pos     = 0;
      frame_seq_low = 8'h00;
      mismatches    = 0;
      requests      = 0;
      checked       = 0;
      headers       = 0;
      payload_bytes = 0;
      aborts        = 0;
      commits       = 0;
    endfunction

    // Advance the frame tracker by one accepted request
    function void note_request(fecp_pkg::in_t req);
      fecp_pkg::out_t res;
      int unsigned    idx;
      int unsigned    prev1;
      int unsigned    prev2;
      logic           fec;
      res = '0;
      requests++;
      // drop bytes past the end of a complete frame
      if (frame_pos >= FRAME_BYTES) begin
        if (req.in_last) frame_pos = 0;
        return;
      end
      // short datagram: abort, commit nothing
      if (req.in_last && frame_pos + 1 < FRAME_BYTES) begin
        res.kind        = fecp_pkg::KIND_HEADER;
        res.frame_abort = 1'b1;
        frame_pos       = 0;
        owed_results.push_back(res);
        return;
      end
      // sequence number; header on its last byte
      if (frame_pos < SEQ_BYTES) begin
        frame_pos++;
        if (frame_pos == SEQ_BYTES) begin
          frame_seq_low = req.in_byte;
          res.kind      = fecp_pkg::KIND_HEADER;
          res.seq_low   = req.in_byte;
          res.has_fec   = ~req.in_byte[0];
          owed_results.push_back(res);
        end
        return;
      end
      // payload byte with parity of the two committed frames
      idx   = frame_pos - SEQ_BYTES;
      prev1 = (write_bank + 2) % 3;
      prev2 = (write_bank + 1) % 3;
      fec   = ~frame_seq_low[0];
      res.kind         = fecp_pkg::KIND_PAYLOAD;
      res.has_fec      = fec;
      res.byte_index   = idx[7:0];
      res.payload_byte = req.in_byte;
      res.parity_byte  = history[prev1][idx] ^ history[prev2][idx];
      res.parity_valid = fec;
      res.frame_done   = (idx == PAYLOAD_BYTES - 1);
      history[write_bank][idx] = req.in_byte;
      if (res.frame_done) begin
        write_bank = (write_bank + 1) % 3;
        frame_pos  = req.in_last ? 0 : FRAME_BYTES;
      end else begin
        frame_pos++;
      end
      owed_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                  checked, name, got, want));
    endtask

    // Compare one result against the oldest owed result
    task check_result(fecp_pkg::out_t got);
      fecp_pkg::out_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing owed: %h", checked, got));
        checked++;
        return;
      end
      want = owed_results.pop_front();
      check_field("kind", 32'(got.kind), 32'(want.kind));
      check_field("seq_low", 32'(got.seq_low), 32'(want.seq_low));
      check_field("has_fec", 32'(got.has_fec), 32'(want.has_fec));
      check_field("byte_index", 32'(got.byte_index), 32'(want.byte_index));
      check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
      check_field("parity_byte", 32'(got.parity_byte), 32'(want.parity_byte));
      check_field("parity_valid", 32'(got.parity_valid), 32'(want.parity_valid));
      check_field("frame_done", 32'(got.frame_done), 32'(want.frame_done));
      check_field("frame_abort", 32'(got.frame_abort), 32'(want.frame_abort));
      if (want.frame_abort) aborts++;
      else if (want.kind == fecp_pkg::KIND_HEADER) headers++;
      else payload_bytes++;
      if (want.frame_done) commits++;
      checked++;
    endtask
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  fecp_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  fecp_pkg::out_t out_data;

  fec_scoreboard sb;
  int unsigned   cycles       = 0;
  int unsigned   random_items = 0;
  int unsigned   results_seen = 0;
  bit            send_idle_on = 1'b1;
  bit            recv_idle_on = 1'b1;

  xor_parity_fec_packetizer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one request from a falling edge and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = send_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data.in_byte  <= b;
    in_data.in_last  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(in_data);
    @(negedge clk);
  endtask

  // Send a datagram of n_bytes frame bytes, then n_extra trailing bytes
  task automatic send_frame(int unsigned n_bytes, int unsigned n_extra);
    int unsigned total;
    total = n_bytes + n_extra;
    for (int unsigned k = 0; k < total; k++)
      send_byte(8'($urandom_range(0, 255)), k == total - 1);
    random_items += n_bytes;
  endtask

  // Result side: random stalls, one long hold to back up the input
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (results_seen == 200) stall = LONG_HOLD;
      else stall = recv_idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      results_seen++;
      if (results_seen % 64 == 0) recv_idle_on = ~recv_idle_on;
      @(negedge clk);
    end
  end

  initial begin
    int unsigned frame_no;
    int unsigned pick;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: aborts at every stage, extreme sequence bytes
    foreach (DIRECTED[i])
      send_byte(DIRECTED[i][8:1], DIRECTED[i][0]);

    // Random: mostly whole frames, some broken ones
    frame_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      send_idle_on = ($urandom_range(0, 3) != 0);
      case (frame_no)
        0: send_frame(FRAME_BYTES, 3);
        1: send_frame(FRAME_BYTES, 0);
        2: send_frame(FRAME_BYTES - 1, 0);
        3: send_frame(FRAME_BYTES, 1);
        default: begin
          pick = $urandom_range(0, 99);
          if (pick < 65)
            send_frame(FRAME_BYTES, $urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
          else if (pick < 85)
            send_frame($urandom_range(1, 8), 0);
          else
            send_frame($urandom_range(9, FRAME_BYTES - 1), 0);
        end
      endcase
      frame_no++;
    end
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d requests in %0d datagram groups, %0d results checked",
             sb.requests, frame_no, sb.checked);
    $display("run: %0d headers, %0d payload bytes, %0d aborts, %0d frames committed",
             sb.headers, sb.payload_bytes, sb.aborts, sb.commits);
    if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
sv/fecp_pkg.sv
sv/fecp_ram.sv
sv/xor_parity_fec_packetizer_core.sv
tb/xor_parity_fec_packetizer_core_test.sv
